// ----- design/slist_pkg.sv -----
// shared types and constants for the sorted list engine
// no dependencies; imported by slist_front, slist_back and sorted_list_engine
package slist_pkg;

    localparam int LIST_DEPTH_DEF = 16;
    localparam int CMDQ_DEPTH_DEF = 2;
    localparam int RESULT_LIMIT   = 32;
    localparam int ENTRY_W        = 6;

    localparam logic [1:0] FUNC_INSERT  = 2'd0;
    localparam logic [1:0] FUNC_DELETE  = 2'd1;
    localparam logic [1:0] FUNC_DISPLAY = 2'd2;
    localparam logic [1:0] FUNC_MERGE   = 2'd3;

    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_FULL    = 2'd1;
    localparam logic [1:0] STATUS_RANGE   = 2'd2;
    localparam logic [1:0] STATUS_NOTHING = 2'd3;

    typedef struct packed {
        logic [1:0]          func;
        logic                list_select;
        logic signed [31:0]  item_value;
        logic [5:0]          position;
    } slist_in_t;

    typedef struct packed {
        logic signed [31:0]  out_value;
        logic [1:0]          status;
        logic [ENTRY_W-1:0]  entry_count;
        logic                last;
    } slist_out_t;

    // classified command handed from the front to the back
    typedef struct packed {
        logic                multi;
        slist_in_t           item;
    } slist_cmd_t;

endpackage

// ----- design/sorted_list_engine.sv -----
// top level of the sorted list engine: front queue feeding the list back end
// depends on slist_pkg, slist_front, slist_back
//
//  channel   handshake          payload              accepted when
//  item      push / full        item   (slist_in_t)  push && !full
//  result    empty / pop        result (slist_out_t) pop && !empty
//
// insert and delete: all list cells shift in parallel in the back end
// display and merge: a setup step in the idle state, then one result per cycle while pop keeps up
// merge runs one compare of the two list heads per result
// a small command queue lets items arrive while a readout is in progress
// reset clears both list counts; list cells hold no reset value

module sorted_list_engine #(
    parameter int LIST_DEPTH = slist_pkg::LIST_DEPTH_DEF,
    parameter int CMDQ_DEPTH = slist_pkg::CMDQ_DEPTH_DEF
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    output logic                    full,
    input  slist_pkg::slist_in_t    item,
    output logic                    empty,
    input  logic                    pop,
    output slist_pkg::slist_out_t   result
);
    import slist_pkg::*;

    slist_cmd_t cmd;
    logic       cmd_valid;
    logic       cmd_pop;

    slist_front #(
        .QUEUE_DEPTH (CMDQ_DEPTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .item      (item),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop)
    );

    slist_back #(
        .LIST_DEPTH (LIST_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop),
        .empty     (empty),
        .pop       (pop),
        .result    (result)
    );

endmodule

// ----- design/slist_front.sv -----
// front end: accepts transactions, classifies them and queues them for the back end
// depends on slist_pkg
module slist_front #(
    parameter int QUEUE_DEPTH = slist_pkg::CMDQ_DEPTH_DEF
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    output logic                    full,
    input  slist_pkg::slist_in_t    item,
    output logic                    cmd_valid,
    output slist_pkg::slist_cmd_t   cmd,
    input  logic                    cmd_pop
);
    import slist_pkg::*;

    localparam int PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

    slist_cmd_t              queue_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]        wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]        rd_ptr_reg, rd_ptr_next;
    logic [FILL_W-1:0]       fill_reg, fill_next;
    slist_cmd_t              new_cmd;
    logic                    do_push, do_pop;

    assign full      = (fill_reg == FILL_W'(QUEUE_DEPTH));
    assign cmd_valid = (fill_reg != '0);
    assign cmd       = queue_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = cmd_pop && cmd_valid;

    always_comb
    begin
        new_cmd       = '0;
        new_cmd.item  = item;
        new_cmd.multi = (item.func == FUNC_DISPLAY) || (item.func == FUNC_MERGE);
    end

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            queue_reg[wr_ptr_reg] <= new_cmd;
        end
    end

endmodule

// ----- design/slist_back.sv -----
// back end: list cells, insert/delete shifters, readout sequencer and result register
// depends on slist_pkg
module slist_back #(
    parameter int LIST_DEPTH = slist_pkg::LIST_DEPTH_DEF
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cmd_valid,
    input  slist_pkg::slist_cmd_t   cmd,
    output logic                    cmd_pop,
    output logic                    empty,
    input  logic                    pop,
    output slist_pkg::slist_out_t   result
);
    import slist_pkg::*;

    localparam int IDX_W = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int CNT_W = $clog2(LIST_DEPTH + 1);
    localparam int TOT_W = (CNT_W + 1 > ENTRY_W) ? CNT_W + 1 : ENTRY_W;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EMIT = 1'b1;

    logic signed [31:0]  list_a_reg [LIST_DEPTH];
    logic signed [31:0]  list_b_reg [LIST_DEPTH];
    logic [CNT_W-1:0]    count_a_reg, count_a_next;
    logic [CNT_W-1:0]    count_b_reg, count_b_next;
    logic                state_reg, state_next;
    logic                merge_reg, merge_next;
    logic                sel_reg, sel_next;
    logic [CNT_W-1:0]    ptr_a_reg, ptr_a_next;
    logic [CNT_W-1:0]    ptr_b_reg, ptr_b_next;
    logic [TOT_W-1:0]    k_reg, k_next;
    logic [TOT_W-1:0]    total_reg, total_next;
    slist_out_t          res_reg, res_next;
    logic                res_valid_reg, res_valid_next;

    logic signed [31:0]  cur [LIST_DEPTH];
    logic signed [31:0]  ins_cell [LIST_DEPTH];
    logic signed [31:0]  del_cell [LIST_DEPTH];
    logic [LIST_DEPTH-1:0] lt;
    logic [CNT_W-1:0]    n;
    logic [5:0]          posm1;
    logic                list_full, del_ok;
    logic                can_emit;
    logic                wr_list;
    logic                wr_ins;
    logic [CNT_W-1:0]    count_new;
    logic [TOT_W-1:0]    sum_ab, total_cmd;
    logic signed [31:0]  head_a, head_b;
    logic                take_a;

    assign can_emit = !res_valid_reg || pop;
    assign empty    = !res_valid_reg;
    assign result   = res_reg;

    // selected list and parallel shift networks
    always_comb
    begin
        n = cmd.item.list_select ? count_b_reg : count_a_reg;
        for (int i = 0; i < LIST_DEPTH; i++)
        begin
            cur[i] = cmd.item.list_select ? list_b_reg[i] : list_a_reg[i];
            lt[i]  = (CNT_W'(i) < n) && (cur[i] < cmd.item.item_value);
        end
        ins_cell[0] = lt[0] ? cur[0] : cmd.item.item_value;
        for (int i = 1; i < LIST_DEPTH; i++)
        begin
            ins_cell[i] = lt[i] ? cur[i] : (lt[i-1] ? cmd.item.item_value : cur[i-1]);
        end
        posm1 = cmd.item.position - 6'd1;
        for (int i = 0; i < LIST_DEPTH - 1; i++)
        begin
            del_cell[i] = (6'(i) >= posm1) ? cur[i+1] : cur[i];
        end
        del_cell[LIST_DEPTH-1] = cur[LIST_DEPTH-1];
    end

    assign list_full = (n == CNT_W'(LIST_DEPTH));
    assign del_ok    = (cmd.item.position != 6'd0) && (cmd.item.position <= 6'(n));
    assign sum_ab    = TOT_W'(count_a_reg) + TOT_W'(count_b_reg);

    always_comb
    begin
        if (cmd.item.func == FUNC_MERGE)
        begin
            total_cmd = (sum_ab > TOT_W'(RESULT_LIMIT)) ? TOT_W'(RESULT_LIMIT) : sum_ab;
        end
        else
        begin
            total_cmd = TOT_W'(n);
        end
    end

    // merge picks from the first list on ties
    assign head_a = list_a_reg[ptr_a_reg[IDX_W-1:0]];
    assign head_b = list_b_reg[ptr_b_reg[IDX_W-1:0]];
    always_comb
    begin
        if (merge_reg)
        begin
            take_a = (ptr_a_reg < count_a_reg)
                  && ((ptr_b_reg >= count_b_reg) || (head_a <= head_b));
        end
        else
        begin
            take_a = !sel_reg;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        merge_next     = merge_reg;
        sel_next       = sel_reg;
        ptr_a_next     = ptr_a_reg;
        ptr_b_next     = ptr_b_reg;
        k_next         = k_reg;
        total_next     = total_reg;
        count_a_next   = count_a_reg;
        count_b_next   = count_b_reg;
        res_next       = res_reg;
        res_valid_next = res_valid_reg && !pop;
        cmd_pop        = 1'b0;
        wr_list        = 1'b0;
        wr_ins         = 1'b0;
        count_new      = n;

        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid && can_emit)
                begin
                    cmd_pop          = 1'b1;
                    res_valid_next   = 1'b1;
                    res_next         = '0;
                    res_next.last    = 1'b1;
                    res_next.entry_count = ENTRY_W'(n);
                    if (cmd.multi)
                    begin
                        if (total_cmd == '0)
                        begin
                            res_next.status      = STATUS_NOTHING;
                            res_next.entry_count = '0;
                        end
                        else
                        begin
                            // first element goes out from the emit state
                            res_valid_next = res_valid_reg && !pop;
                            state_next     = ST_EMIT;
                            merge_next     = (cmd.item.func == FUNC_MERGE);
                            sel_next       = cmd.item.list_select;
                            ptr_a_next     = '0;
                            ptr_b_next     = '0;
                            k_next         = '0;
                            total_next     = total_cmd;
                        end
                    end
                    else if (cmd.item.func == FUNC_INSERT)
                    begin
                        if (list_full)
                        begin
                            res_next.status = STATUS_FULL;
                        end
                        else
                        begin
                            wr_list              = 1'b1;
                            wr_ins               = 1'b1;
                            count_new            = n + 1'b1;
                            res_next.status      = STATUS_OK;
                            res_next.entry_count = ENTRY_W'(count_new);
                        end
                    end
                    else
                    begin
                        if (!del_ok)
                        begin
                            res_next.status = STATUS_RANGE;
                        end
                        else
                        begin
                            wr_list              = 1'b1;
                            count_new            = n - 1'b1;
                            res_next.status      = STATUS_OK;
                            res_next.entry_count = ENTRY_W'(count_new);
                        end
                    end
                    if (wr_list)
                    begin
                        if (cmd.item.list_select)
                        begin
                            count_b_next = count_new;
                        end
                        else
                        begin
                            count_a_next = count_new;
                        end
                    end
                end
            end
            ST_EMIT:
            begin
                if (can_emit)
                begin
                    res_valid_next       = 1'b1;
                    res_next.out_value   = take_a ? head_a : head_b;
                    res_next.status      = STATUS_OK;
                    res_next.entry_count = ENTRY_W'(total_reg);
                    res_next.last        = (k_reg + 1'b1 == total_reg);
                    k_next               = k_reg + 1'b1;
                    if (take_a)
                    begin
                        ptr_a_next = ptr_a_reg + 1'b1;
                    end
                    else
                    begin
                        ptr_b_next = ptr_b_reg + 1'b1;
                    end
                    if (k_reg + 1'b1 == total_reg)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_a_reg   <= '0;
            count_b_reg   <= '0;
            res_valid_reg <= 1'b0;
            merge_reg     <= 1'b0;
            sel_reg       <= 1'b0;
            ptr_a_reg     <= '0;
            ptr_b_reg     <= '0;
            k_reg         <= '0;
            total_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            count_a_reg   <= count_a_next;
            count_b_reg   <= count_b_next;
            res_valid_reg <= res_valid_next;
            merge_reg     <= merge_next;
            sel_reg       <= sel_next;
            ptr_a_reg     <= ptr_a_next;
            ptr_b_reg     <= ptr_b_next;
            k_reg         <= k_next;
            total_reg     <= total_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
        for (int i = 0; i < LIST_DEPTH; i++)
        begin
            if (wr_list && !cmd.item.list_select)
            begin
                list_a_reg[i] <= wr_ins ? ins_cell[i] : del_cell[i];
            end
            if (wr_list && cmd.item.list_select)
            begin
                list_b_reg[i] <= wr_ins ? ins_cell[i] : del_cell[i];
            end
        end
    end

    a_count_a_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_a_reg <= CNT_W'(LIST_DEPTH))
        else $error("first list count beyond depth");

    a_count_b_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_b_reg <= CNT_W'(LIST_DEPTH))
        else $error("second list count beyond depth");

    a_emit_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) |-> (k_reg < total_reg))
        else $error("readout ran past its total");

    a_ptr_track: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) |-> (TOT_W'(ptr_a_reg) + TOT_W'(ptr_b_reg) == k_reg))
        else $error("readout pointers out of step with element count");

    a_no_pop_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) |-> !cmd_pop)
        else $error("command taken during readout");

endmodule
